[rtl/isd_pkg.sv]
// shared types, constants and helpers for the imu step detector
package isd_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam int ACC_W   = 15;
    localparam int GYR_W   = 12;
    localparam int THR_W   = 12;
    localparam int ASQ_W   = 30;
    localparam int GSQ_W   = 24;
    localparam int ROOT_W  = 15;
    localparam int Q8_W    = 23;
    localparam int ALPHA_W = 9;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 4;

    localparam int LANES      = 7;
    localparam int SQ_STEPS   = 15;
    localparam int ROOT_STEPS = 15;
    localparam int FILT_STEPS = 9;

    localparam int IN_W  = 120;
    localparam int OUT_W = 40;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [Q8_W-1:0]    SMOOTH_RESET = 23'd256000;

    typedef enum logic [2:0] {
        REG_IMPACT   = 3'd0,
        REG_SWING    = 3'd1,
        REG_COOLDOWN = 3'd2,
        REG_TIMEOUT  = 3'd3,
        REG_ALPHA    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_FILT,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic load;
        logic run;
    } step_ctl_t;

    // counter as reported on the 16-bit output field
    function automatic logic [15:0] count_view(input logic [COUNT_WIDTH-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        count_view = (w > 33'd65535) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

[rtl/isd_sqsum.sv]
// bit-serial sums of squares for accel, gyro and the swing threshold
module isd_sqsum (
    input  logic                                clk,
    input  isd_pkg::step_ctl_t                  ctl,
    input  logic signed [isd_pkg::ACC_W-1:0]    accel_x,
    input  logic signed [isd_pkg::ACC_W-1:0]    accel_y,
    input  logic signed [isd_pkg::ACC_W-1:0]    accel_z,
    input  logic signed [isd_pkg::GYR_W-1:0]    gyro_x,
    input  logic signed [isd_pkg::GYR_W-1:0]    gyro_y,
    input  logic signed [isd_pkg::GYR_W-1:0]    gyro_z,
    input  logic [isd_pkg::THR_W-1:0]           thr,
    output logic [isd_pkg::ASQ_W-1:0]           acc_sum,
    output logic [isd_pkg::GSQ_W-1:0]           gyr_sum,
    output logic [isd_pkg::GSQ_W-1:0]           thr_sq
);

    logic [isd_pkg::ACC_W-1:0] mag [isd_pkg::LANES];
    logic [isd_pkg::ASQ_W-1:0] term [isd_pkg::LANES];

    logic [isd_pkg::ASQ_W-1:0] mc_reg [isd_pkg::LANES];
    logic [isd_pkg::ACC_W-1:0] mp_reg [isd_pkg::LANES];
    logic [isd_pkg::ASQ_W-1:0] acc_a_reg, acc_a_next;
    logic [isd_pkg::GSQ_W-1:0] acc_g_reg, acc_g_next;
    logic [isd_pkg::GSQ_W-1:0] acc_t_reg, acc_t_next;

    function automatic logic [isd_pkg::ACC_W-1:0] abs_a(input logic signed [isd_pkg::ACC_W-1:0] v);
        abs_a = v[isd_pkg::ACC_W-1] ? isd_pkg::ACC_W'(-v) : isd_pkg::ACC_W'(v);
    endfunction

    function automatic logic [isd_pkg::ACC_W-1:0] abs_g(input logic signed [isd_pkg::GYR_W-1:0] v);
        logic [isd_pkg::GYR_W-1:0] m;
        m = v[isd_pkg::GYR_W-1] ? isd_pkg::GYR_W'(-v) : isd_pkg::GYR_W'(v);
        abs_g = isd_pkg::ACC_W'(m);
    endfunction

    always_comb
    begin
        mag[0] = abs_a(accel_x);
        mag[1] = abs_a(accel_y);
        mag[2] = abs_a(accel_z);
        mag[3] = abs_g(gyro_x);
        mag[4] = abs_g(gyro_y);
        mag[5] = abs_g(gyro_z);
        mag[6] = isd_pkg::ACC_W'(thr);
    end

    // one multiplier bit per lane per cycle
    always_comb
    begin
        for (int i = 0; i < isd_pkg::LANES; i++)
        begin
            term[i] = mp_reg[i][0] ? mc_reg[i] : '0;
        end
        acc_a_next = acc_a_reg + term[0] + term[1] + term[2];
        acc_g_next = acc_g_reg + term[3][isd_pkg::GSQ_W-1:0] + term[4][isd_pkg::GSQ_W-1:0]
                   + term[5][isd_pkg::GSQ_W-1:0];
        acc_t_next = acc_t_reg + term[6][isd_pkg::GSQ_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < isd_pkg::LANES; i++)
            begin
                mc_reg[i] <= isd_pkg::ASQ_W'(mag[i]);
                mp_reg[i] <= mag[i];
            end
            acc_a_reg <= '0;
            acc_g_reg <= '0;
            acc_t_reg <= '0;
        end
        else if (ctl.run)
        begin
            for (int i = 0; i < isd_pkg::LANES; i++)
            begin
                mc_reg[i] <= mc_reg[i] << 1;
                mp_reg[i] <= mp_reg[i] >> 1;
            end
            acc_a_reg <= acc_a_next;
            acc_g_reg <= acc_g_next;
            acc_t_reg <= acc_t_next;
        end
    end

    assign acc_sum = acc_a_reg;
    assign gyr_sum = acc_g_reg;
    assign thr_sq  = acc_t_reg;

endmodule

[rtl/isd_isqrt.sv]
// floor integer square root, one result bit per cycle
module isd_isqrt (
    input  logic                          clk,
    input  isd_pkg::step_ctl_t            ctl,
    input  logic [isd_pkg::ASQ_W-1:0]     n,
    output logic [isd_pkg::ROOT_W-1:0]    root
);

    localparam int REM_W = isd_pkg::ROOT_W + 2;
    localparam int SH_W  = REM_W + 2;

    logic [isd_pkg::ASQ_W-1:0]  n_reg, n_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [isd_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [SH_W-1:0]            rem_sh;
    logic [SH_W-1:0]            trial;

    always_comb
    begin
        rem_sh = {rem_reg, n_reg[isd_pkg::ASQ_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        n_next = n_reg << 2;
        if (rem_sh >= trial)
        begin
            rem_next  = REM_W'(rem_sh - trial);
            root_next = {root_reg[isd_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh[REM_W-1:0];
            root_next = {root_reg[isd_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            n_reg    <= n;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctl.run)
        begin
            n_reg    <= n_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

[rtl/isd_ewma.sv]
// exponential average, weights applied one bit per cycle
module isd_ewma (
    input  logic                           clk,
    input  isd_pkg::step_ctl_t             ctl,
    input  logic [isd_pkg::ROOT_W-1:0]     raw,
    input  logic [isd_pkg::ALPHA_W-1:0]    alpha,
    input  logic [isd_pkg::Q8_W-1:0]       smooth,
    output logic [isd_pkg::Q8_W-1:0]       smooth_new
);

    localparam int ACC_W = isd_pkg::Q8_W + 8;

    logic [isd_pkg::ALPHA_W-1:0] a_clamp;
    logic [isd_pkg::ALPHA_W-1:0] ma_reg, mb_reg;
    logic [ACC_W-1:0]            cr_reg, cs_reg;
    logic [ACC_W-1:0]            acc_reg, acc_next;

    always_comb
    begin
        a_clamp  = (alpha > isd_pkg::ALPHA_ONE) ? isd_pkg::ALPHA_ONE : alpha;
        acc_next = acc_reg + (ma_reg[0] ? cr_reg : '0) + (mb_reg[0] ? cs_reg : '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            ma_reg  <= a_clamp;
            mb_reg  <= isd_pkg::ALPHA_ONE - a_clamp;
            cr_reg  <= ACC_W'({raw, 8'h00});
            cs_reg  <= ACC_W'(smooth);
            acc_reg <= '0;
        end
        else if (ctl.run)
        begin
            ma_reg  <= ma_reg >> 1;
            mb_reg  <= mb_reg >> 1;
            cr_reg  <= cr_reg << 1;
            cs_reg  <= cs_reg << 1;
            acc_reg <= acc_next;
        end
    end

    assign smooth_new = acc_reg[ACC_W-1:8];

endmodule

[rtl/imu_step_detector_core.sv]
// top level of the imu step detector: sequencer, step state and stream ports
//
// One request on s_axis carries one IMU sample; every sample gives exactly one
// result on m_axis. The block works on one sample at a time: tready is high
// only while the sequencer is idle. A sample goes through three serial units:
// sums of squares (one multiplier bit per cycle), the square root (one root
// bit per cycle) and the smoothing filter (one weight bit per cycle), then
// the decision state. A new sample can be taken in the cycle after the result
// is loaded, so each sample passes through the three serial units in series
// before the next one is accepted.
// The result sits in an output register; if the receiver stalls, the next
// sample is still accepted and processed, and the sequencer holds in its
// decision cycle until the output register is free.
// Configuration writes on the cfg channel are always taken (cfg_ready is high)
// and must only be made while the block is idle.
// Reset clears the configuration to its defaults, the filter to 1000 mg, the
// swing flag, both time stamps and the step count.
module imu_step_detector_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms, zero pad
    input  logic [isd_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // step_seen, step_total, smoothed_mg, swing_active, zero pad
    output logic [isd_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_addr,
    input  logic [15:0]                   cfg_data
);

    isd_pkg::state_t                  state_reg, state_next;
    logic [isd_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    logic [14:0]                      impact_reg;
    logic [isd_pkg::THR_W-1:0]        swing_thr_reg;
    logic [15:0]                      cooldown_reg;
    logic [15:0]                      timeout_reg;
    logic [isd_pkg::ALPHA_W-1:0]      alpha_reg;

    logic [isd_pkg::TIME_W-1:0]       time_reg;
    logic [isd_pkg::Q8_W-1:0]         smooth_reg, smooth_next;
    logic                             swing_reg, swing_next;
    logic [isd_pkg::TIME_W-1:0]       last_swing_reg, last_swing_next;
    logic [isd_pkg::TIME_W-1:0]       last_step_reg, last_step_next;
    logic [isd_pkg::COUNT_WIDTH-1:0]  count_reg, count_next;
    logic                             seen_next;

    logic                             out_valid_reg, out_valid_next;
    logic [isd_pkg::OUT_W-1:0]        out_data_reg, out_data_next;

    isd_pkg::step_ctl_t               sq_ctl, root_ctl, filt_ctl;
    logic [isd_pkg::ASQ_W-1:0]        acc_sum;
    logic [isd_pkg::GSQ_W-1:0]        gyr_sum, thr_sq;
    logic [isd_pkg::ROOT_W-1:0]       root;
    logic [isd_pkg::Q8_W-1:0]         smooth_new;

    logic                             accept;
    logic                             commit;
    logic                             swing_set;
    logic                             impact_hit;
    logic [isd_pkg::TIME_W-1:0]       since_swing;
    logic [isd_pkg::TIME_W-1:0]       since_step;

    isd_sqsum u_sqsum (
        .clk     (clk),
        .ctl     (sq_ctl),
        .accel_x (s_axis_tdata[14:0]),
        .accel_y (s_axis_tdata[29:15]),
        .accel_z (s_axis_tdata[44:30]),
        .gyro_x  (s_axis_tdata[56:45]),
        .gyro_y  (s_axis_tdata[68:57]),
        .gyro_z  (s_axis_tdata[80:69]),
        .thr     (swing_thr_reg),
        .acc_sum (acc_sum),
        .gyr_sum (gyr_sum),
        .thr_sq  (thr_sq)
    );

    isd_isqrt u_isqrt (
        .clk  (clk),
        .ctl  (root_ctl),
        .n    (acc_sum),
        .root (root)
    );

    isd_ewma u_ewma (
        .clk        (clk),
        .ctl        (filt_ctl),
        .raw        (root),
        .alpha      (alpha_reg),
        .smooth     (smooth_reg),
        .smooth_new (smooth_new)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == isd_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sq_ctl     = '0;
        root_ctl   = '0;
        filt_ctl   = '0;
        commit     = 1'b0;
        unique case (state_reg)
            isd_pkg::ST_IDLE:
            begin
                sq_ctl.load = accept;
                cnt_next    = '0;
                if (accept)
                begin
                    state_next = isd_pkg::ST_SQ;
                end
            end
            isd_pkg::ST_SQ:
            begin
                sq_ctl.run = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == isd_pkg::CNT_W'(isd_pkg::SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = isd_pkg::ST_ROOT;
                end
            end
            isd_pkg::ST_ROOT:
            begin
                root_ctl.load = (cnt_reg == '0);
                root_ctl.run  = (cnt_reg != '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == isd_pkg::CNT_W'(isd_pkg::ROOT_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = isd_pkg::ST_FILT;
                end
            end
            isd_pkg::ST_FILT:
            begin
                filt_ctl.load = (cnt_reg == '0);
                filt_ctl.run  = (cnt_reg != '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == isd_pkg::CNT_W'(isd_pkg::FILT_STEPS))
                begin
                    cnt_next   = '0;
                    state_next = isd_pkg::ST_DECIDE;
                end
            end
            isd_pkg::ST_DECIDE:
            begin
                commit = !out_valid_reg || m_axis_tready;
                if (commit)
                begin
                    state_next = isd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isd_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // swing gating and step decision
    always_comb
    begin
        swing_set       = gyr_sum > thr_sq;
        last_swing_next = swing_set ? time_reg : last_swing_reg;
        swing_next      = swing_set || swing_reg;
        since_swing     = time_reg - last_swing_next;
        if (swing_next && (since_swing > isd_pkg::TIME_W'(timeout_reg)))
        begin
            swing_next = 1'b0;
        end
        smooth_next    = smooth_new;
        impact_hit     = smooth_new > {impact_reg, 8'h00};
        since_step     = time_reg - last_step_reg;
        seen_next      = 1'b0;
        count_next     = count_reg;
        last_step_next = last_step_reg;
        if (impact_hit && swing_next && (since_step > isd_pkg::TIME_W'(cooldown_reg)))
        begin
            seen_next      = 1'b1;
            swing_next     = 1'b0;
            last_step_next = time_reg;
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        out_data_next = {7'b0000000, swing_next, smooth_new[isd_pkg::Q8_W-1:8],
                         isd_pkg::count_view(count_next), seen_next};
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg     <= isd_pkg::SMOOTH_RESET;
            swing_reg      <= 1'b0;
            last_swing_reg <= '0;
            last_step_reg  <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                smooth_reg     <= smooth_next;
                swing_reg      <= swing_next;
                last_swing_reg <= last_swing_next;
                last_step_reg  <= last_step_next;
                count_reg      <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg <= s_axis_tdata[112:81];
        end
        if (commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            impact_reg    <= 15'd1250;
            swing_thr_reg <= 12'd60;
            cooldown_reg  <= 16'd300;
            timeout_reg   <= 16'd500;
            alpha_reg     <= 9'd77;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                isd_pkg::REG_IMPACT:   impact_reg    <= cfg_data[14:0];
                isd_pkg::REG_SWING:    swing_thr_reg <= cfg_data[11:0];
                isd_pkg::REG_COOLDOWN: cooldown_reg  <= cfg_data;
                isd_pkg::REG_TIMEOUT:  timeout_reg   <= cfg_data;
                isd_pkg::REG_ALPHA:    alpha_reg     <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTH
    // a counted step always leaves the swing flag clear
    a_step_clears_swing: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[32])
        else $error("step reported with swing still active");

    // a result appears only out of the decision cycle
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == isd_pkg::ST_DECIDE))
        else $error("result loaded outside the decision cycle");

    // the step count never goes down
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("step count decreased");

    // a free output register never holds the sequencer in its decision cycle
    a_decide_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isd_pkg::ST_DECIDE && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("decision cycle stalled with free output");
`endif

endmodule

[bench/imu_step_detector_core_tb.sv]
// testbench for imu_step_detector_core: sample stream, register phases, step predictor
module imu_step_detector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 80;
    localparam int TAIL_CYCLES  = 64;

    typedef struct {
        logic signed [isd_pkg::ACC_W-1:0] ax, ay, az;
        logic signed [isd_pkg::GYR_W-1:0] gx, gy, gz;
        logic [isd_pkg::TIME_W-1:0]       t;
    } imu_sample_t;

    typedef struct {
        logic        seen;
        logic [15:0] total;
        logic [14:0] mg;
        logic        swing;
    } step_result_t;

    // keeps its own copy of the detector state and predicts one result per sample
    class step_board;
        logic [14:0] impact_thr;
        logic [11:0] swing_thr;
        logic [15:0] cooldown;
        logic [15:0] timeout;
        logic [8:0]  alpha;

        logic [31:0]       smooth_q8;
        bit                swing;
        logic [31:0]       last_swing;
        logic [31:0]       last_step;
        longint unsigned   count;

        step_result_t expected_q[$];
        int errors;
        int results;
        int steps;

        function new();
            impact_thr = 15'd1250;
            swing_thr  = 12'd60;
            cooldown   = 16'd300;
            timeout    = 16'd500;
            alpha      = 9'd77;
            smooth_q8  = 32'(isd_pkg::SMOOTH_RESET);
            swing      = 1'b0;
            last_swing = '0;
            last_step  = '0;
            count      = 0;
            errors     = 0;
            results    = 0;
            steps      = 0;
        endfunction

        function void set_reg(isd_pkg::cfg_reg_t r, logic [15:0] v);
            case (r)
                isd_pkg::REG_IMPACT:   impact_thr = v[14:0];
                isd_pkg::REG_SWING:    swing_thr  = v[11:0];
                isd_pkg::REG_COOLDOWN: cooldown   = v;
                isd_pkg::REG_TIMEOUT:  timeout    = v;
                isd_pkg::REG_ALPHA:    alpha      = v[8:0];
                default: ;
            endcase
        endfunction

        function longint unsigned floor_root(longint unsigned n);
            longint unsigned res;
            longint unsigned probe;
            res = 0;
            probe = 64'h4000_0000_0000_0000;
            while (probe > n)
                probe = probe >> 2;
            while (probe != 0) begin
                if (n >= res + probe) begin
                    n = n - (res + probe);
                    res = (res >> 1) + probe;
                end
                else
                    res = res >> 1;
                probe = probe >> 2;
            end
            return res;
        endfunction

        function void note_sample(imu_sample_t s);
            longint          ax, ay, az, gx, gy, gz;
            longint unsigned acc2, gyr2, raw, a, thr2;
            longint unsigned cmax;
            step_result_t    r;
            ax = s.ax; ay = s.ay; az = s.az;
            gx = s.gx; gy = s.gy; gz = s.gz;
            acc2 = ax * ax + ay * ay + az * az;
            gyr2 = gx * gx + gy * gy + gz * gz;
            raw  = floor_root(acc2);
            a    = (alpha > 9'd256) ? 256 : alpha;
            thr2 = longint'(swing_thr) * longint'(swing_thr);
            cmax = (64'd1 << isd_pkg::COUNT_WIDTH) - 1;
            r.seen = 1'b0;

            smooth_q8 = 32'((a * (raw << 8) + (256 - a) * longint'(smooth_q8)) >> 8);

            if (gyr2 > thr2) begin
                swing = 1'b1;
                last_swing = s.t;
            end
            if (swing && (32'(s.t - last_swing) > 32'(timeout)))
                swing = 1'b0;

            if (longint'(smooth_q8) > (longint'(impact_thr) << 8)) begin
                if (swing && (32'(s.t - last_step) > 32'(cooldown))) begin
                    if (count < cmax)
                        count++;
                    last_step = s.t;
                    swing = 1'b0;
                    r.seen = 1'b1;
                end
            end

            r.total = (count > 65535) ? 16'hFFFF : count[15:0];
            r.mg    = smooth_q8[22:8];
            r.swing = swing;
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [isd_pkg::OUT_W-1:0] d);
            step_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result 0x%h with no sample waiting", $time, d);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results++;
            if (d[0])
                steps++;
            field_check("step_seen", want.seen, d[0]);
            field_check("step_total", want.total, d[16:1]);
            field_check("smoothed_mg", want.mg, d[31:17]);
            field_check("swing_active", want.swing, d[32]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [isd_pkg::IN_W-1:0]    s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [isd_pkg::OUT_W-1:0]   m_axis_tdata;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [2:0]                  cfg_addr;
    logic [15:0]                 cfg_data;

    step_board   board;
    bit          no_idle;
    int          rx_hold;
    int          cycles;
    int          sent;
    logic [31:0] clock_ms;

    imu_step_detector_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // result side: random stalls, results checked as they are taken
    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 4) == 0) begin
                rx_hold = pick_gap();
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic imu_sample_t mk(int ax, int ay, int az, int gx, int gy, int gz,
                                       logic [31:0] t);
        imu_sample_t s;
        s.ax = ax[isd_pkg::ACC_W-1:0]; s.ay = ay[isd_pkg::ACC_W-1:0];
        s.az = az[isd_pkg::ACC_W-1:0];
        s.gx = gx[isd_pkg::GYR_W-1:0]; s.gy = gy[isd_pkg::GYR_W-1:0];
        s.gz = gz[isd_pkg::GYR_W-1:0];
        s.t  = t;
        return s;
    endfunction

    // valid stays high across back-to-back requests; lowered only when a gap follows
    task automatic push_sample(imu_sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= isd_pkg::IN_W'({s.t, s.gz, s.gy, s.gx, s.az, s.ay, s.ax});
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_sample(s);
        sent++;
    endtask

    task automatic write_reg(isd_pkg::cfg_reg_t r, logic [15:0] v);
        cfg_addr  <= r;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(r, v);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apply_phase(int ph);
        logic [15:0] v[5];
        case (ph)
            1: v = '{16'd800, 16'd100, 16'd50, 16'd200, 16'd256};
            2: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd511};
            3: v = '{16'd32767, 16'd4000, 16'd65535, 16'd65535, 16'd0};
            5: v = '{16'd1500, 16'd60, 16'd300, 16'd500, 16'd300};
            default: v = '{16'($urandom_range(0, 4000)), 16'($urandom_range(0, 400)),
                           16'($urandom_range(0, 600)), 16'($urandom_range(0, 1000)),
                           16'($urandom_range(0, 511))};
        endcase
        write_reg(isd_pkg::REG_IMPACT, v[0]);
        write_reg(isd_pkg::REG_SWING, v[1]);
        write_reg(isd_pkg::REG_COOLDOWN, v[2]);
        write_reg(isd_pkg::REG_TIMEOUT, v[3]);
        write_reg(isd_pkg::REG_ALPHA, v[4]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            clock_ms = clock_ms + $urandom_range(1, 120);
        else if (r < 95)
            clock_ms = clock_ms + $urandom_range(121, 700);
        else
            clock_ms = $urandom;
        return clock_ms;
    endfunction

    function automatic int rsign(int v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic quiet_sample();
        push_sample(mk(rsign($urandom_range(0, 300)), rsign($urandom_range(0, 300)),
                       $urandom_range(700, 1300), rsign($urandom_range(0, 40)),
                       rsign($urandom_range(0, 40)), rsign($urandom_range(0, 40)),
                       next_time()));
    endtask

    // one leg swing followed by impacts and a settle, the pattern that counts steps
    task automatic stride(output int n);
        int k, g;
        g = int'(board.swing_thr) + 1 + $urandom_range(0, 300);
        if (g > 2047)
            g = 2047;
        push_sample(mk(rsign($urandom_range(0, 400)), rsign($urandom_range(0, 400)),
                       $urandom_range(800, 1200), rsign(g), rsign($urandom_range(0, 200)),
                       rsign($urandom_range(0, 200)), next_time()));
        n = 1;
        k = $urandom_range(2, 6);
        repeat (k) begin
            push_sample(mk(rsign($urandom_range(0, 2000)), rsign($urandom_range(0, 2000)),
                           rsign($urandom_range(1500, 16000)), rsign($urandom_range(0, 100)),
                           rsign($urandom_range(0, 100)), rsign($urandom_range(0, 100)),
                           next_time()));
            n++;
        end
        k = $urandom_range(1, 3);
        repeat (k) begin
            quiet_sample();
            n++;
        end
    endtask

    task automatic random_part();
        int n, got, r;
        imu_sample_t s;
        n = 0;
        while (n < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                stride(got);
                n += got;
            end
            else if (r < 80) begin
                quiet_sample();
                n++;
            end
            else if (r < 95) begin
                // any bit pattern, out-of-range values included
                s.ax = isd_pkg::ACC_W'($urandom);
                s.ay = isd_pkg::ACC_W'($urandom);
                s.az = isd_pkg::ACC_W'($urandom);
                s.gx = isd_pkg::GYR_W'($urandom);
                s.gy = isd_pkg::GYR_W'($urandom);
                s.gz = isd_pkg::GYR_W'($urandom);
                s.t  = $urandom;
                clock_ms = s.t;
                push_sample(s);
                n++;
            end
            else begin
                // repeated or backwards timestamp
                clock_ms = clock_ms - $urandom_range(0, 50);
                push_sample(mk(0, 0, rsign($urandom_range(0, 16000)), rsign($urandom_range(0, 2000)),
                               0, 0, clock_ms));
                n++;
            end
        end
    endtask

    task automatic directed_part();
        push_sample(mk(0, 0, 0, 0, 0, 0, 32'd0));
        push_sample(mk(-16384, -16384, -16384, -2048, -2048, -2048, 32'd10));
        push_sample(mk(16383, 16383, 16383, 2047, 2047, 2047, 32'd20));
        push_sample(mk(16000, -16000, 16000, 2000, -2000, 2000, 32'd30));
        // gyro exactly at the threshold does not start a swing
        push_sample(mk(0, 0, 1000, 60, 0, 0, 32'd400));
        push_sample(mk(0, 0, 1000, 61, 0, 0, 32'd410));
        // impact inside the cooldown, then just past it
        push_sample(mk(0, 0, 16000, 0, 0, 0, 32'd420));
        push_sample(mk(0, 0, 16000, 0, 0, 0, 32'd701));
        // swing timeout: at the limit, then one past
        push_sample(mk(0, 0, 1000, -500, 0, 0, 32'd720));
        push_sample(mk(0, 0, 1000, 0, 0, 0, 32'd1220));
        push_sample(mk(0, 0, 1000, 0, 0, 0, 32'd1221));
        push_sample(mk(0, 0, 1000, 0, 0, 0, 32'd1300));
        // timestamp wrap and a timestamp going backwards
        push_sample(mk(0, 0, 16000, 0, 300, 0, 32'hFFFF_FFF0));
        push_sample(mk(0, 0, 16000, 0, 0, 0, 32'h0000_0010));
        push_sample(mk(0, 0, 16000, 100, 0, 0, 32'd5));
        push_sample(mk(-1, -1, -1, -1, -1, -1, 32'h8000_0000));
        push_sample(mk(-16000, 0, 0, 0, -2000, 0, 32'h8000_0400));
        push_sample(mk(0, 16000, 0, 0, 0, -2000, 32'h8000_0800));
        push_sample(mk(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        clock_ms = 32'd2000;
    endtask

    initial
    begin
        int ph;
        board         = new();
        sent          = 0;
        no_idle       = 1'b0;
        clock_ms      = '0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_addr      <= isd_pkg::REG_IMPACT;
        cfg_data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                apply_phase(ph);
            end
            no_idle = (ph == 2 || ph == 5);
            if (ph == 0)
                directed_part();
            random_part();
            s_axis_tvalid <= 1'b0;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d samples over %0d register settings, %0d results checked, %0d steps seen",
                 sent, PHASES, board.results, board.steps);
        $display("%0d mismatches, %0d results still outstanding", board.errors, board.pending());
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/isd_pkg.sv
rtl/isd_sqsum.sv
rtl/isd_isqrt.sv
rtl/isd_ewma.sv
rtl/imu_step_detector_core.sv
bench/imu_step_detector_core_tb.sv
